/* src/frame_header_validator_macros.svh */
// ----------------------------------------------------------------------------
// Frame header validator assertion macros
// Clocked assertion helpers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_HEADER_VALIDATOR_MACROS_SVH
`define FRAME_HEADER_VALIDATOR_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define FHV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame header validator: property violated");
// The expression must never be true at a clock edge outside reset.
`define FHV_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("frame header validator: forbidden condition seen");
`else
`define FHV_ASSERT(label, prop)
`define FHV_NEVER(label, expr)
`endif
`endif

/* src/fhv_pkg.sv */
// ----------------------------------------------------------------------------
// Frame header validator package
// Sizes, status codes and register indexes of the frame header validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhv_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int COUNT_W      = 16;
    localparam int WORD_W       = 16;
    localparam int CFG_IDX_W    = 2;

    // Output word layout: out_byte, status, func_code, data_size, then zero fill.
    localparam int OUT_DATA_W   = 48;
    localparam int OUT_USED_W   = 8 + 3 + WORD_W + WORD_W;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_SHORT       = 3'd1;
    localparam status_t ST_MAGIC       = 3'd2;
    localparam status_t ST_LEN_LOW     = 3'd3;
    localparam status_t ST_LEN_MISMATCH = 3'd4;
    localparam status_t ST_FUNC_MISMATCH = 3'd5;
    localparam status_t ST_SIZE_MISMATCH = 3'd6;
    localparam status_t ST_UNEXP_PAYLOAD = 3'd7;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_MAGIC_VALUE   = 2'd0;
    localparam cfg_idx_t CFG_READ_RESP     = 2'd1;
    localparam cfg_idx_t CFG_WRITE_REQ     = 2'd2;

endpackage

`default_nettype wire

/* src/frame_header_validator.sv */
// ----------------------------------------------------------------------------
// Frame header validator
// Captures a ten-byte frame header, forwards payload bytes and checks the
// header against the received length on the last byte of each frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "frame_header_validator_macros.svh"

// The block takes one frame byte per word on the slave side, with s_tlast on
// the last byte, and accepts a word in every clock cycle while s_tready is
// high. Each accepted word is handled in the cycle it arrives: the byte
// counter, the header capture and all header checks are one level of logic
// that feeds a single output register, so a result appears on the master
// side in the cycle after its input word is accepted. Header bytes that do
// not end a frame give no output word. Payload bytes (everything after the
// first ten bytes) leave at once with m_tuser high, even if the frame fails
// later. The word carrying the last byte has m_tlast high and reports the
// verdict and the decoded function and data size fields. The output register
// sits behind s_tready, so a new byte is taken while a finished word still
// waits, as long as the master side takes that word in the same cycle.
// Configuration registers may only be written while no frame is in flight.
module frame_header_validator
    import fhv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire cfg_idx_t              cfg_index,
    input  wire logic [WORD_W-1:0]     cfg_wdata,

    // Input bytes.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] in_byte
    input  wire logic                  s_tlast,   // frame_end

    // Results.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] out_byte, [10:8] status, [26:11] func_code, [42:27] data_size,
    // [47:43] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,   // byte_valid
    output logic                       m_tlast    // frame_done
);

    // Configuration registers.
    logic [WORD_W-1:0] magic_value_reg;
    logic [WORD_W-1:0] read_resp_code_reg;
    logic [WORD_W-1:0] write_req_code_reg;

    // Frame state.
    logic [7:0]         header_reg [HEADER_BYTES];
    logic [7:0]         header_next [HEADER_BYTES];
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic               saturated_reg;
    logic               saturated_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_user_reg;
    logic                  out_user_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    logic                  accept;
    logic                  is_payload;
    logic                  count_full;
    logic [HDR_IDX_W-1:0]  hdr_idx;
    logic                  short_frame;
    logic                  data_func;
    logic [WORD_W-1:0]     f_func;
    logic [WORD_W-1:0]     f_magic;
    logic [WORD_W-1:0]     f_length;
    logic [WORD_W-1:0]     f_func2;
    logic [WORD_W-1:0]     f_dsize;
    status_t               verdict;
    logic [WORD_W-1:0]     rep_func;
    logic [WORD_W-1:0]     rep_dsize;
    logic [7:0]            rep_byte;

    // A new byte is taken whenever the output register is free or drains now.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_payload = saturated_reg || (byte_count_reg >= COUNT_W'(HEADER_BYTES));
    assign count_full = (byte_count_reg == {COUNT_W{1'b1}});
    assign hdr_idx    = byte_count_reg[HDR_IDX_W-1:0];

    // Header image with the current byte merged in, so a frame that ends on
    // its tenth byte is checked against the complete header.
    always_comb
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            header_next[i] = header_reg[i];
            if (!is_payload && (hdr_idx == HDR_IDX_W'(i)))
            begin
                header_next[i] = s_tdata;
            end
        end
    end

    assign byte_count_next = count_full ? byte_count_reg : byte_count_reg + COUNT_W'(1);
    assign saturated_next  = saturated_reg || count_full;

    // Little-endian header fields.
    assign f_func   = {header_next[1], header_next[0]};
    assign f_magic  = {header_next[3], header_next[2]};
    assign f_length = {header_next[5], header_next[4]};
    assign f_func2  = {header_next[7], header_next[6]};
    assign f_dsize  = {header_next[9], header_next[8]};

    assign short_frame = !saturated_next && (byte_count_next < COUNT_W'(HEADER_BYTES));
    assign data_func   = (f_func == read_resp_code_reg) || (f_func == write_req_code_reg);

    // Checks run in a fixed priority; the first failure names the verdict.
    always_comb
    begin
        verdict = ST_OK;
        if (short_frame)
        begin
            verdict = ST_SHORT;
        end
        else if (f_magic != magic_value_reg)
        begin
            verdict = ST_MAGIC;
        end
        else if (f_length < WORD_W'(HEADER_BYTES))
        begin
            verdict = ST_LEN_LOW;
        end
        else if (saturated_next || (f_length != byte_count_next))
        begin
            verdict = ST_LEN_MISMATCH;
        end
        else if (f_func != f_func2)
        begin
            verdict = ST_FUNC_MISMATCH;
        end
        else if (data_func)
        begin
            if (f_dsize != (f_length - WORD_W'(HEADER_BYTES)))
            begin
                verdict = ST_SIZE_MISMATCH;
            end
        end
        else if (f_length != WORD_W'(HEADER_BYTES))
        begin
            verdict = ST_UNEXP_PAYLOAD;
        end
    end

    // Fields that carry no meaning in a word are reported as zero.
    always_comb
    begin
        rep_byte  = is_payload ? s_tdata : 8'd0;
        rep_func  = '0;
        rep_dsize = '0;
        if (s_tlast && !short_frame)
        begin
            rep_func  = f_func;
            rep_dsize = f_dsize;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (accept)
        begin
            out_valid_next = is_payload || s_tlast;
            out_data_next  = {(OUT_DATA_W - OUT_USED_W)'(0), rep_dsize, rep_func,
                              (s_tlast ? verdict : ST_OK), rep_byte};
            out_user_next  = is_payload;
            out_last_next  = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_value_reg    <= '0;
            read_resp_code_reg <= '0;
            write_req_code_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC_VALUE: magic_value_reg    <= cfg_wdata;
                CFG_READ_RESP:   read_resp_code_reg <= cfg_wdata;
                CFG_WRITE_REQ:   write_req_code_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Count and saturation return to zero after the last byte of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                byte_count_reg <= '0;
                saturated_reg  <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                saturated_reg  <= saturated_next;
            end
        end
    end

    // Every header byte is rewritten before a full-length frame reads it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            header_reg <= header_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // A word that does not end a frame must be a payload byte with no verdict.
    `FHV_ASSERT(a_mid_word_is_payload,
        (m_tvalid && !m_tlast) |-> (m_tuser && (m_tdata[10:8] == ST_OK)))
    // A short frame never reports header fields or payload.
    `FHV_ASSERT(a_short_has_no_fields,
        (m_tvalid && m_tlast && (m_tdata[10:8] == ST_SHORT)) |->
        ((m_tdata[42:11] == 32'd0) && !m_tuser))
    // The frame state is cleared after the last byte is taken.
    `FHV_ASSERT(a_clear_after_last,
        (s_tvalid && s_tready && s_tlast) |=> ((byte_count_reg == '0) && !saturated_reg))
    // Saturation only happens once the counter sits at its top value.
    `FHV_NEVER(a_saturated_count_top,
        saturated_reg && (byte_count_reg != {COUNT_W{1'b1}}))
    // A word is only produced by an accepted byte.
    `FHV_ASSERT(a_valid_from_accept,
        ($rose(m_tvalid)) |-> $past(s_tvalid && s_tready))

endmodule

`default_nettype wire
